/* hdl/pairwise_speaker_panner_macros.svh */
// Assertion helpers for the panner checker.
`ifndef PAIRWISE_SPEAKER_PANNER_MACROS_SVH
`define PAIRWISE_SPEAKER_PANNER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PWSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define PWSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that also holds around reset.
`define PWSP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/pwsp_pkg.sv */
package pwsp_pkg;

  localparam int DEF_MAX_SPEAKERS = 8;
  localparam int DEF_ANGLE_BITS   = 16;
  localparam int DEF_GAIN_BITS    = 16;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CH_BITS    = 3;
  localparam int SLOT_BITS  = 16;   // angle slot pitch in the angle words
  localparam int SLOTS_LOW  = 4;    // speakers held in the low angle word

  localparam int Q_BITS   = 30;     // phase fraction bits
  localparam int U_W      = Q_BITS + 1;
  localparam int P_W      = 32;
  localparam int SINE_LAT = 6;

  localparam logic [P_W-1:0] SC9 = 32'd172272;
  localparam logic [P_W-1:0] HORNER_C [4] = '{32'd5026995, 32'd85569306,
                                              32'd693598668, 32'd1686629713};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_SPEAKER_COUNT = 3'd1,
    REG_ANGLES_LOW    = 3'd2,
    REG_ANGLES_HIGH   = 3'd3,
    REG_CHANNELS      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MONO = 2'd1,
    KIND_PAIR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CH_BITS-1:0] cha;
    logic [CH_BITS-1:0] chb;
  } meta_t;

endpackage

/* hdl/pwsp_if.sv */
interface pwsp_in_if import pwsp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] source_angle;

  modport source (output valid, output source_angle, input ready);
  modport sink   (input valid, input source_angle, output ready);
endinterface

interface pwsp_out_if import pwsp_pkg::*; #(
  parameter int GAIN_BITS = DEF_GAIN_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  logic [CH_BITS-1:0]   channel_a;
  logic [CH_BITS-1:0]   channel_b;
  logic [GAIN_BITS-1:0] gain_a;
  logic [GAIN_BITS-1:0] gain_b;

  modport source (output valid, output valid_res, output channel_a, output channel_b,
                  output gain_a, output gain_b, input ready);
  modport sink   (input valid, input valid_res, input channel_a, input channel_b,
                  input gain_a, input gain_b, output ready);
endinterface

/* hdl/pwsp_div.sv */
// Restoring divider, one quotient bit per stage: quot = floor(num * 2^Q_BITS / span).
module pwsp_div import pwsp_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS:0]   num,
  input  logic [ANGLE_BITS:0]   span,
  output logic [Q_BITS-1:0]     quot
);
  localparam int RW = ANGLE_BITS + 1;

  logic [RW-1:0]     rem [Q_BITS];
  logic [RW-1:0]     spn [Q_BITS];
  logic [Q_BITS-1:0] q   [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_st
    logic [RW-1:0]     r_src, s_src;
    logic [Q_BITS-1:0] q_src;
    logic [RW:0]       r2;
    logic              ge;
    if (k == 0) begin : g_first
      assign r_src = num;
      assign s_src = span;
      assign q_src = '0;
    end else begin : g_next
      assign r_src = rem[k-1];
      assign s_src = spn[k-1];
      assign q_src = q[k-1];
    end
    assign r2 = {r_src, 1'b0};
    assign ge = r2 >= {1'b0, s_src};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? RW'(r2 - {1'b0, s_src}) : r2[RW-1:0];
        spn[k] <= s_src;
        q[k]   <= {q_src[Q_BITS-2:0], ge};
      end
    end
  end

  assign quot = q[Q_BITS-1];
endmodule

/* hdl/pwsp_sine.sv */
// sin(pi/2 * u), u in Q30: square, four Horner steps, final multiply.
module pwsp_sine import pwsp_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [U_W-1:0] u,
  output logic [P_W-1:0] s
);
  logic [U_W-1:0]      ua  [5];
  logic [U_W-1:0]      u2a [5];
  logic [P_W-1:0]      pa  [5];
  logic [2*U_W-1:0]    sq;
  logic [P_W+U_W-1:0]  fin;

  assign sq = u * u;
  assign pa[0] = SC9;

  always_ff @(posedge clk) begin
    if (en) begin
      ua[0]  <= u;
      u2a[0] <= sq[2*Q_BITS:Q_BITS];
    end
  end

  for (genvar k = 1; k <= 4; k++) begin : g_horner
    logic [P_W+U_W-1:0] pr;
    assign pr = pa[k-1] * u2a[k-1];
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]  <= HORNER_C[k-1] - pr[Q_BITS+P_W-1:Q_BITS];
        ua[k]  <= ua[k-1];
        u2a[k] <= u2a[k-1];
      end
    end
  end

  assign fin = pa[4] * ua[4];

  always_ff @(posedge clk) begin
    if (en) s <= fin[Q_BITS+P_W-1:Q_BITS];
  end
endmodule

/* hdl/pairwise_speaker_panner.sv */
// Pipeline: 41 register stages (3 scan, 30 divider, 1 phase, 6 sine, 1 output);
//   the first scan stage loads at the accepting edge itself.
// Throughput: one word per cycle; an output stall freezes the whole pipeline
//   together, so nothing is dropped or repeated.
// Reset (rst, synchronous, active high): config registers to 0, valid bits cleared.
module pairwise_speaker_panner import pwsp_pkg::*; #(
  parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
  parameter int GAIN_BITS    = DEF_GAIN_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pwsp_in_if.sink               in_ch,
  pwsp_out_if.source            out_ch
);
  localparam int IW      = $clog2(MAX_SPEAKERS);
  localparam int W       = ANGLE_BITS + 2;   // signed, holds x - turn
  localparam int TURN_I  = 1 << ANGLE_BITS;
  localparam int DIV_LAT = Q_BITS;
  localparam int SH      = Q_BITS - (GAIN_BITS - 1);
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << (GAIN_BITS - 1);
  localparam logic signed [W-1:0]  TURN     = W'(TURN_I);

  // ---------------- configuration registers ----------------
  logic [7:0]            channel_count;
  logic [3:0]            speaker_count;
  logic [CFG_DATA_W-1:0] angles_low, angles_high;
  logic [23:0]           speaker_channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= '0;
      speaker_count    <= '0;
      angles_low       <= '0;
      angles_high      <= '0;
      speaker_channels <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count    <= cfg_data[7:0];
        REG_SPEAKER_COUNT: speaker_count    <= cfg_data[3:0];
        REG_ANGLES_LOW:    angles_low       <= cfg_data;
        REG_ANGLES_HIGH:   angles_high      <= cfg_data;
        REG_CHANNELS:      speaker_channels <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Per-speaker angle and channel taps.
  logic [ANGLE_BITS-1:0] ang [MAX_SPEAKERS];
  logic [CH_BITS-1:0]    chn [MAX_SPEAKERS];
  for (genvar i = 0; i < MAX_SPEAKERS; i++) begin : g_spk
    if (i < SLOTS_LOW) begin : g_lo
      assign ang[i] = angles_low[SLOT_BITS*i +: ANGLE_BITS];
    end else begin : g_hi
      assign ang[i] = angles_high[SLOT_BITS*(i-SLOTS_LOW) +: ANGLE_BITS];
    end
    assign chn[i] = speaker_channels[CH_BITS*i +: CH_BITS];
  end

  // Effective speaker count, saturated at the table size.
  logic [3:0]    n_eff;
  logic [IW-1:0] last_idx;
  assign n_eff    = (speaker_count > 4'(MAX_SPEAKERS)) ? 4'(MAX_SPEAKERS) : speaker_count;
  assign last_idx = IW'(n_eff - 4'd1);

  // The whole pipe moves as one; the output register is the last stage.
  logic adv;
  logic vo;
  assign adv         = !vo || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: input register ----------------
  logic                  v1;
  logic [ANGLE_BITS-1:0] x1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) x1 <= in_ch.source_angle[ANGLE_BITS-1:0];
  end

  // Wrap x below the last speaker, then bracket it against every pair at once.
  logic signed [W-1:0] last_s, xw, prev_s [MAX_SPEAKERS];
  logic signed [W-1:0] ang_s [MAX_SPEAKERS];
  logic [MAX_SPEAKERS-1:0] hit;
  logic                    hit_any;
  logic [IW-1:0]           hit_idx;
  kind_t                   kind1;

  assign last_s = W'(ang[last_idx]);
  assign xw     = (W'(x1) >= last_s) ? W'(x1) - TURN : W'(x1);

  for (genvar i = 0; i < MAX_SPEAKERS; i++) begin : g_hit
    if (i == 0) begin : g_wrap
      assign prev_s[i] = last_s - TURN;
    end else begin : g_adj
      assign prev_s[i] = W'(ang[i-1]);
    end
    // signed compare: xw goes negative after the wrap
    assign ang_s[i] = W'(ang[i]);
    assign hit[i] = (4'(i) < n_eff) && (xw >= prev_s[i]) && (xw < ang_s[i]);
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = MAX_SPEAKERS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
    end
    if (channel_count == 8'd0)      kind1 = KIND_NONE;
    else if (channel_count == 8'd1) kind1 = KIND_MONO;
    else if (!hit_any)              kind1 = KIND_NONE;   // no speakers or no bracket
    else                            kind1 = KIND_PAIR;
  end

  // ---------------- stage 2: selected pair ----------------
  logic                v2;
  kind_t               kind2;
  logic [IW-1:0]       idx2, lidx2;
  logic signed [W-1:0] xw2, last2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind2 <= kind1;
      idx2  <= hit_idx;
      lidx2 <= last_idx;
      xw2   <= xw;
      last2 <= last_s;
    end
  end

  logic signed [W-1:0] a2, p2, num_w, span_w;
  logic [IW-1:0]       pidx2;
  assign a2     = W'(ang[idx2]);
  assign p2     = (idx2 == '0) ? last2 - TURN : W'(ang[IW'(idx2 - 1'b1)]);
  assign pidx2  = (idx2 == '0) ? lidx2 : IW'(idx2 - 1'b1);
  assign num_w  = xw2 - p2;
  assign span_w = a2 - p2;

  // ---------------- stage 3: divider operands ----------------
  logic                v3;
  meta_t               meta3;
  logic [ANGLE_BITS:0] num3, span3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      meta3.kind <= kind2;
      meta3.cha  <= chn[pidx2];
      meta3.chb  <= chn[idx2];
      num3       <= num_w[ANGLE_BITS:0];
      span3      <= span_w[ANGLE_BITS:0];
    end
  end

  // ---------------- phase divider ----------------
  logic [Q_BITS-1:0]  t_q;
  logic [DIV_LAT-1:0] vd;
  meta_t              md [DIV_LAT];

  pwsp_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
    .clk (clk), .en (adv), .num (num3), .span (span3), .quot (t_q)
  );

  always_ff @(posedge clk) begin
    if (rst) vd <= '0;
    else if (adv) vd <= {vd[DIV_LAT-2:0], v3};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      md[0] <= meta3;
      for (int k = 1; k < DIV_LAT; k++) md[k] <= md[k-1];
    end
  end

  // ---------------- phase and its complement ----------------
  logic           vu;
  meta_t          mu;
  logic [U_W-1:0] u_b, u_a;
  always_ff @(posedge clk) begin
    if (rst) vu <= 1'b0;
    else if (adv) vu <= vd[DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mu  <= md[DIV_LAT-1];
      u_b <= {1'b0, t_q};
      u_a <= (U_W'(1) << Q_BITS) - {1'b0, t_q};
    end
  end

  // ---------------- sine lanes ----------------
  logic [P_W-1:0]      s_b, s_a;
  logic [SINE_LAT-1:0] vs;
  meta_t               ms [SINE_LAT];

  pwsp_sine u_sin_b (.clk (clk), .en (adv), .u (u_b), .s (s_b));
  pwsp_sine u_sin_a (.clk (clk), .en (adv), .u (u_a), .s (s_a));

  always_ff @(posedge clk) begin
    if (rst) vs <= '0;
    else if (adv) vs <= {vs[SINE_LAT-2:0], vu};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ms[0] <= mu;
      for (int k = 1; k < SINE_LAT; k++) ms[k] <= ms[k-1];
    end
  end

  // Round Q30 to the gain format, halves up, clamp at one.
  function automatic logic [GAIN_BITS-1:0] to_gain(input logic [P_W-1:0] s);
    logic [P_W:0] sum;
    logic [P_W:0] g;
    sum = {1'b0, s} + ((P_W+1)'(1) << (SH - 1));
    g   = sum >> SH;
    return (g > (P_W+1)'(GAIN_ONE)) ? GAIN_ONE : g[GAIN_BITS-1:0];
  endfunction

  // ---------------- output register ----------------
  meta_t mo;
  always_comb mo = ms[SINE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (adv) vo <= vs[SINE_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      case (mo.kind)
        KIND_PAIR: begin
          out_ch.valid_res <= 1'b1;
          out_ch.channel_a <= mo.cha;
          out_ch.channel_b <= mo.chb;
          out_ch.gain_a    <= to_gain(s_a);
          out_ch.gain_b    <= to_gain(s_b);
        end
        KIND_MONO: begin
          out_ch.valid_res <= 1'b1;
          out_ch.channel_a <= '0;
          out_ch.channel_b <= '0;
          out_ch.gain_a    <= GAIN_ONE;
          out_ch.gain_b    <= '0;
        end
        default: begin
          out_ch.valid_res <= 1'b0;
          out_ch.channel_a <= '0;
          out_ch.channel_b <= '0;
          out_ch.gain_a    <= '0;
          out_ch.gain_b    <= '0;
        end
      endcase
    end
  end
  assign out_ch.valid = vo;
endmodule

/* hdl/pwsp_checker.sv */
`include "pairwise_speaker_panner_macros.svh"

module pwsp_checker import pwsp_pkg::*; #(
  parameter int GAIN_BITS = DEF_GAIN_BITS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 valid_res,
  input logic [CH_BITS-1:0]   channel_a,
  input logic [CH_BITS-1:0]   channel_b,
  input logic [GAIN_BITS-1:0] gain_a,
  input logic [GAIN_BITS-1:0] gain_b
);
  localparam logic [GAIN_BITS-1:0] ONE = GAIN_BITS'(1) << (GAIN_BITS - 1);

  `PWSP_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) == 1'b1, !out_valid, "output valid after reset")
  `PWSP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "stalled word dropped")
  `PWSP_ASSERT_NOW(a_gain_range, clk, rst, out_valid, gain_a <= ONE && gain_b <= ONE, "gain above one")
  `PWSP_ASSERT_NOW(a_error_zero, clk, rst, out_valid && !valid_res, channel_a == '0 && channel_b == '0 && gain_a == '0 && gain_b == '0, "error word not zero")
endmodule

bind pairwise_speaker_panner pwsp_checker #(.GAIN_BITS(GAIN_BITS)) u_pwsp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .valid_res (out_ch.valid_res),
  .channel_a (out_ch.channel_a),
  .channel_b (out_ch.channel_b),
  .gain_a    (out_ch.gain_a),
  .gain_b    (out_ch.gain_b)
);

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pwsp_pkg::*;

  // Fixed setup of the block as built here
  localparam int GAIN_W     = DEF_GAIN_BITS;
  localparam int NSPK       = DEF_MAX_SPEAKERS;
  localparam int ABITS      = DEF_ANGLE_BITS;
  localparam int PIPE_DEPTH = 41;
  localparam int RAND_ITEMS = 1500;
  localparam int RAND_SETS  = 12;
  localparam longint unsigned GONE = 64'd1 << (GAIN_W - 1);

  // Pan word as it leaves the block
  typedef struct {
    logic              valid_res;
    logic [2:0]        channel_a;
    logic [2:0]        channel_b;
    logic [GAIN_W-1:0] gain_a;
    logic [GAIN_W-1:0] gain_b;
  } pan_word_t;

  // One full register setting
  typedef struct {
    logic [7:0]  chans;
    logic [3:0]  spk_n;
    logic [63:0] ang_lo;
    logic [63:0] ang_hi;
    logic [23:0] spk_ch;
  } layout_t;

  // Directed row: layout number, source angle, and a typed-in answer where obvious
  typedef struct {
    int        layout;
    logic [15:0] angle;
    bit        known;
    pan_word_t answer;
  } pan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pwsp_in_if                       angle_ch ();
  pwsp_out_if #(.GAIN_BITS(GAIN_W)) pan_ch ();

  pairwise_speaker_panner #(
    .MAX_SPEAKERS(NSPK),
    .ANGLE_BITS  (ABITS),
    .GAIN_BITS   (GAIN_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (angle_ch),
    .out_ch   (pan_ch)
  );

  always #6 clk = ~clk;

  // Live layout as the block holds it, mirrored here for prediction
  layout_t   live;
  pan_word_t pending_pans[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_bad = 0;
  int        n_checked = 0;
  int        n_layouts = 0;

  // Q30 sine of a quarter turn times u, odd degree-9 series, truncating
  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned u2, p;
    u2 = (u * u) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995    - ((p * u2) >> 30);
    p  = 64'd85569306   - ((p * u2) >> 30);
    p  = 64'd693598668  - ((p * u2) >> 30);
    p  = 64'd1686629713 - ((p * u2) >> 30);
    return (p * u) >> 30;
  endfunction

  // Q30 to gain format, round half up, clamp at one
  function automatic longint unsigned q30_to_gain(longint unsigned s);
    longint unsigned g;
    g = (s + (64'd1 << (30 - GAIN_W))) >> (31 - GAIN_W);
    return (g > GONE) ? GONE : g;
  endfunction

  function automatic longint spk_angle(layout_t l, int i);
    logic [63:0] w;
    w = (i < SLOTS_LOW) ? l.ang_lo : l.ang_hi;
    return longint'(w[(i % SLOTS_LOW)*SLOT_BITS +: SLOT_BITS]);
  endfunction

  function automatic pan_word_t predict_pan(layout_t l, logic [15:0] angle);
    pan_word_t r;
    int n, prev_i;
    longint x, last_a, prev_a, a;
    longint unsigned t;
    r = '{1'b0, 3'd0, 3'd0, '0, '0};
    if (l.chans == 0) return r;
    if (l.chans == 1) begin
      r.valid_res = 1'b1;
      r.gain_a = GONE[GAIN_W-1:0];
      return r;
    end
    n = (l.spk_n > NSPK) ? NSPK : int'(l.spk_n);
    if (n == 0) return r;
    x = longint'(angle);
    last_a = spk_angle(l, n - 1);
    if (x >= last_a) x -= (64'sd1 << ABITS);
    prev_a = last_a - (64'sd1 << ABITS);
    prev_i = n - 1;
    for (int i = 0; i < n; i++) begin
      a = spk_angle(l, i);
      if (x >= prev_a && x < a) begin
        t = ($unsigned(x - prev_a) << 30) / $unsigned(a - prev_a);
        r.valid_res = 1'b1;
        r.channel_a = l.spk_ch[prev_i*3 +: 3];
        r.channel_b = l.spk_ch[i*3 +: 3];
        r.gain_a = GAIN_W'(q30_to_gain(quarter_sine((64'd1 << 30) - t)));
        r.gain_b = GAIN_W'(q30_to_gain(quarter_sine(t)));
        return r;
      end
      prev_a = a;
      prev_i = i;
    end
    return r;
  endfunction

  // Receiver: random back-pressure, compare each word with the oldest pending pan
  always @(posedge clk) begin
    pan_word_t want;
    if (rst) begin
      pan_ch.ready <= 1'b0;
    end else begin
      if (pan_ch.valid && pan_ch.ready) begin
        if (pending_pans.size() == 0) begin
          $error("unexpected pan word: valid_res=%0b", pan_ch.valid_res);
          n_bad++;
        end else begin
          want = pending_pans.pop_front();
          n_checked++;
          if (pan_ch.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, pan_ch.valid_res);
            n_bad++;
          end
          if (pan_ch.channel_a !== want.channel_a) begin
            $error("channel_a: expected %0d, got %0d", want.channel_a, pan_ch.channel_a);
            n_bad++;
          end
          if (pan_ch.channel_b !== want.channel_b) begin
            $error("channel_b: expected %0d, got %0d", want.channel_b, pan_ch.channel_b);
            n_bad++;
          end
          if (pan_ch.gain_a !== want.gain_a) begin
            $error("gain_a: expected %0d, got %0d", want.gain_a, pan_ch.gain_a);
            n_bad++;
          end
          if (pan_ch.gain_b !== want.gain_b) begin
            $error("gain_b: expected %0d, got %0d", want.gain_b, pan_ch.gain_b);
            n_bad++;
          end
        end
      end
      pan_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Only between phases: wait for every pending pan, then let the pipe settle
  task automatic load_layout(layout_t l);
    while (pending_pans.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    write_reg(REG_CHANNEL_COUNT, 64'(l.chans));
    write_reg(REG_SPEAKER_COUNT, 64'(l.spk_n));
    write_reg(REG_ANGLES_LOW,    l.ang_lo);
    write_reg(REG_ANGLES_HIGH,   l.ang_hi);
    write_reg(REG_CHANNELS,      64'(l.spk_ch));
    live = l;
    n_layouts++;
  endtask

  // One angle word; prediction is taken at the accepting edge
  task automatic send_angle(logic [15:0] angle, bit known, pan_word_t answer);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.source_angle <= angle;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
    pending_pans.push_back(known ? answer : predict_pan(live, angle));
  endtask

  // Random layout: mostly a sorted table, sometimes raw or oversized counts
  function automatic layout_t random_layout();
    layout_t l;
    logic [15:0] a[8];
    logic [15:0] tmp;
    int pick;
    pick = $urandom_range(99);
    l.chans = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd1 : 8'($urandom_range(255, 2));
    l.spk_n = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    if (l.spk_n == 0 && $urandom_range(1)) l.spk_n = 4'd1;
    foreach (a[i]) a[i] = 16'($urandom);
    if ($urandom_range(5) != 0) begin
      for (int i = 0; i < 8; i++)
        for (int j = 0; j < 7 - i; j++)
          if (a[j] > a[j+1]) begin
            tmp = a[j]; a[j] = a[j+1]; a[j+1] = tmp;
          end
    end
    l.ang_lo = {a[3], a[2], a[1], a[0]};
    l.ang_hi = {a[7], a[6], a[5], a[4]};
    l.spk_ch = 24'($urandom);
    return l;
  endfunction

  layout_t   fixed_layouts[8];
  pan_row_t  pan_rows[$];

  function automatic pan_row_t row(int lay, logic [15:0] ang, bit known, pan_word_t ans);
    pan_row_t r;
    r.layout = lay; r.angle = ang; r.known = known; r.answer = ans;
    return r;
  endfunction

  initial begin
    pan_word_t silent, mono, none;
    int cur_layout;
    int per_set;
    silent = '{1'b0, 3'd0, 3'd0, '0, '0};
    mono   = '{1'b1, 3'd0, 3'd0, GONE[GAIN_W-1:0], '0};
    none   = silent;

    angle_ch.valid = 1'b0;
    angle_ch.source_angle = '0;
    pan_ch.ready = 1'b0;

    // 0: reset state, no channels
    fixed_layouts[0] = '{8'd0, 4'd0, 64'd0, 64'd0, 24'd0};
    // 1: mono over a quad table
    fixed_layouts[1] = '{8'd1, 4'd4, 64'hC000_8000_4000_0000, 64'd0, 24'o3210};
    // 2: channels but no speakers
    fixed_layouts[2] = '{8'd2, 4'd0, 64'hC000_8000_4000_0000, 64'd0, 24'o3210};
    // 3: plain quad
    fixed_layouts[3] = '{8'd8, 4'd4, 64'hC000_8000_4000_0000, 64'd0, 24'o3210};
    // 4: lone speaker spans the whole turn
    fixed_layouts[4] = '{8'd2, 4'd1, 64'h0000_0000_0000_03E8, 64'd0, 24'o5};
    // 5: table out of order
    fixed_layouts[5] = '{8'd3, 4'd3, 64'h0000_C350_2710_7530, 64'd0, 24'o764};
    // 6: count above the table size, all channels, widest config
    fixed_layouts[6] = '{8'd255, 4'd15, 64'h6000_4000_2000_0100,
                         64'hFF00_E000_C000_8000, 24'o01234567};
    // 7: every speaker at the top angle
    fixed_layouts[7] = '{8'd255, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF};

    pan_rows.push_back(row(0, 16'h0000, 1, silent));
    pan_rows.push_back(row(0, 16'hFFFF, 1, silent));
    pan_rows.push_back(row(1, 16'h0000, 1, mono));
    pan_rows.push_back(row(1, 16'h9C40, 1, mono));
    pan_rows.push_back(row(2, 16'h1234, 1, none));
    pan_rows.push_back(row(2, 16'hFFFF, 1, none));
    pan_rows.push_back(row(3, 16'h0000, 0, silent));
    pan_rows.push_back(row(3, 16'h2000, 0, silent));
    pan_rows.push_back(row(3, 16'h4000, 0, silent));
    pan_rows.push_back(row(3, 16'hC000, 0, silent));
    pan_rows.push_back(row(3, 16'hFFFF, 0, silent));
    pan_rows.push_back(row(4, 16'h03E8, 0, silent));
    pan_rows.push_back(row(4, 16'h0000, 0, silent));
    pan_rows.push_back(row(4, 16'h03E7, 0, silent));
    pan_rows.push_back(row(5, 16'h1388, 0, silent));
    pan_rows.push_back(row(5, 16'h4E20, 0, silent));
    pan_rows.push_back(row(5, 16'h9C40, 0, silent));
    pan_rows.push_back(row(5, 16'hEA60, 0, silent));
    pan_rows.push_back(row(6, 16'h0000, 0, silent));
    pan_rows.push_back(row(6, 16'hFFFF, 0, silent));
    pan_rows.push_back(row(6, 16'h7530, 0, silent));
    pan_rows.push_back(row(6, 16'hFF80, 0, silent));
    pan_rows.push_back(row(7, 16'hFFFF, 0, silent));
    pan_rows.push_back(row(7, 16'h0000, 0, silent));

    live = fixed_layouts[0];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling; layout 0 is the reset state itself
    cur_layout = 0;
    foreach (pan_rows[k]) begin
      if (pan_rows[k].layout != cur_layout) begin
        angle_ch.valid <= 1'b0;
        load_layout(fixed_layouts[pan_rows[k].layout]);
        cur_layout = pan_rows[k].layout;
      end
      send_angle(pan_rows[k].angle, pan_rows[k].known, pan_rows[k].answer);
    end

    // Random part: each layout gets its own idling mode, rotating
    per_set = RAND_ITEMS / RAND_SETS;
    for (int s = 0; s < RAND_SETS; s++) begin
      angle_ch.valid <= 1'b0;
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      load_layout(random_layout());
      for (int k = 0; k < per_set; k++)
        send_angle(($urandom_range(7) == 0) ? 16'(live.ang_lo[15:0] + $urandom_range(2) - 1)
                                            : 16'($urandom), 0, silent);
    end
    angle_ch.valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending_pans.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Ran %0d layouts, %0d pan words checked across four idling modes.",
             n_layouts, n_checked);
    if (n_bad == 0 && pending_pans.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
